// ----- rtl/lcd_pixel_unpack_palette_defines.svh -----
// assertion macros for the lcd pixel unpacker
// used by the top level only; expects clk and rst in scope
`ifndef LCD_PIXEL_UNPACK_PALETTE_DEFINES_SVH
`define LCD_PIXEL_UNPACK_PALETTE_DEFINES_SVH

// same-cycle implication
`define LPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lpu_pkg.sv -----
// shared types, constants and tint tables for the lcd pixel unpacker
// no dependencies
`default_nettype none
package lpu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 20;
  localparam int BPR_W      = 10;
  localparam int FB_W       = 21;

  localparam logic [1:0] REG_LCD_CONTROL    = 2'd0;
  localparam logic [1:0] REG_GREY_PALETTE   = 2'd1;
  localparam logic [1:0] REG_DISPLAY_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DISPLAY_HEIGHT = 2'd3;

  localparam logic [1:0] MODE_1BPP = 2'd0;
  localparam logic [1:0] MODE_2BPP = 2'd1;
  localparam logic [1:0] MODE_4BPP = 2'd2;

  typedef struct packed {
    logic [31:0]      lcd_control;
    logic [DIM_W-1:0] display_width;
    logic [DIM_W-1:0] display_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [1:0]       mode;
    logic             blank;
    logic             eof;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] line_px;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // n is the inverted 4-bit level, grey = n * 0x11
  function automatic logic [7:0] red_of(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd0: r = 8'd0;     4'd1: r = 8'd10;    4'd2: r = 8'd20;    4'd3: r = 8'd30;
      4'd4: r = 8'd40;    4'd5: r = 8'd51;    4'd6: r = 8'd61;    4'd7: r = 8'd71;
      4'd8: r = 8'd81;    4'd9: r = 8'd91;    4'd10: r = 8'd102;  4'd11: r = 8'd112;
      4'd12: r = 8'd122;  4'd13: r = 8'd132;  4'd14: r = 8'd142;  default: r = 8'd153;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] green_of(input logic [3:0] n);
    logic [7:0] g;
    case (n)
      4'd0: g = 8'd0;     4'd1: g = 8'd11;    4'd2: g = 8'd22;    4'd3: g = 8'd34;
      4'd4: g = 8'd45;    4'd5: g = 8'd56;    4'd6: g = 8'd68;    4'd7: g = 8'd79;
      4'd8: g = 8'd90;    4'd9: g = 8'd102;   4'd10: g = 8'd113;  4'd11: g = 8'd124;
      4'd12: g = 8'd136;  4'd13: g = 8'd147;  4'd14: g = 8'd158;  default: g = 8'd170;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] blue_of(input logic [3:0] n);
    logic [7:0] b;
    case (n)
      4'd0: b = 8'd0;     4'd1: b = 8'd9;     4'd2: b = 8'd18;    4'd3: b = 8'd27;
      4'd4: b = 8'd36;    4'd5: b = 8'd45;    4'd6: b = 8'd54;    4'd7: b = 8'd63;
      4'd8: b = 8'd72;    4'd9: b = 8'd81;    4'd10: b = 8'd90;   4'd11: b = 8'd99;
      4'd12: b = 8'd108;  4'd13: b = 8'd117;  4'd14: b = 8'd126;  default: b = 8'd136;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lpu_front.sv -----
// front end: accepts frame bytes, tracks raster position, builds byte descriptors
// depends on lpu_pkg
`default_nettype none
module lpu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lpu_pkg::cfg_t cfg,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // frame_byte
  input  wire logic          q_full,
  output logic               push,
  output lpu_pkg::desc_t     push_desc
);

  logic [lpu_pkg::POS_W-1:0] byte_in_row, byte_in_row_next;
  logic [lpu_pkg::POS_W-1:0] row_number, row_number_next;
  logic [lpu_pkg::CNT_W-1:0] frame_byte_count, frame_byte_count_next;

  logic [1:0]                 mode;
  logic [lpu_pkg::DIM_W-1:0]  w, h, line_px;
  logic [lpu_pkg::BPR_W-1:0]  bpr;
  logic [1:0]                 ppb_log;
  logic [lpu_pkg::FB_W-1:0]   fb_bytes, buf_bytes, valid_bytes;
  logic [lpu_pkg::POS_W-1:0]  bir_e, row_e;
  logic [lpu_pkg::CNT_W-1:0]  cnt_e;
  logic [lpu_pkg::DIM_W-1:0]  bir_inc, row_inc;
  logic                       out_of_range, last_byte, in_buffer;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    if (cfg.lcd_control[31]) begin
      mode = lpu_pkg::MODE_4BPP;
    end else if (cfg.lcd_control[30]) begin
      mode = lpu_pkg::MODE_2BPP;
    end else begin
      mode = lpu_pkg::MODE_1BPP;
    end

    w = cfg.display_width;
    if (w < lpu_pkg::DIM_W'(16)) w = lpu_pkg::DIM_W'(16);
    if (w > lpu_pkg::DIM_W'(lpu_pkg::MAX_WIDTH)) w = lpu_pkg::DIM_W'(lpu_pkg::MAX_WIDTH);
    w = {w[lpu_pkg::DIM_W-1:3], 3'b000};
    h = cfg.display_height;
    if (h < lpu_pkg::DIM_W'(1)) h = lpu_pkg::DIM_W'(1);
    if (h > lpu_pkg::DIM_W'(lpu_pkg::MAX_HEIGHT)) h = lpu_pkg::DIM_W'(lpu_pkg::MAX_HEIGHT);

    case (mode)
      lpu_pkg::MODE_2BPP: ppb_log = 2'd2;
      lpu_pkg::MODE_4BPP: ppb_log = 2'd1;
      default:            ppb_log = 2'd3;
    endcase
    bpr = lpu_pkg::BPR_W'(w >> ppb_log);

    out_of_range = ({1'b0, byte_in_row} >= {1'b0, bpr}) ||
                   ({1'b0, row_number} >= h);
    bir_e = out_of_range ? '0 : byte_in_row;
    row_e = out_of_range ? '0 : row_number;
    cnt_e = out_of_range ? '0 : frame_byte_count;

    line_px = {lpu_pkg::DIM_W'({1'b0, cfg.lcd_control[18:13]} + 7'd1)} << 4;
    if (line_px > w) line_px = w;
    buf_bytes = lpu_pkg::FB_W'({cfg.lcd_control[12:0], 4'b0000}) + lpu_pkg::FB_W'(16);
    fb_bytes  = lpu_pkg::FB_W'(bpr) * lpu_pkg::FB_W'(h);
    valid_bytes = (buf_bytes < fb_bytes) ? buf_bytes : fb_bytes;
    in_buffer = lpu_pkg::FB_W'(cnt_e) < valid_bytes;

    bir_inc = lpu_pkg::DIM_W'(bir_e) + lpu_pkg::DIM_W'(1);
    row_inc = lpu_pkg::DIM_W'(row_e) + lpu_pkg::DIM_W'(1);
    last_byte = (bir_inc == lpu_pkg::DIM_W'(bpr)) && (row_inc == h);

    if (last_byte) begin
      byte_in_row_next      = '0;
      row_number_next       = '0;
      frame_byte_count_next = '0;
    end else begin
      frame_byte_count_next = cnt_e + lpu_pkg::CNT_W'(1);
      if (bir_inc >= lpu_pkg::DIM_W'(bpr)) begin
        byte_in_row_next = '0;
        row_number_next  = row_inc[lpu_pkg::POS_W-1:0];
      end else begin
        byte_in_row_next = bir_inc[lpu_pkg::POS_W-1:0];
        row_number_next  = row_e;
      end
    end

    push_desc.frame_byte = s_tdata;
    push_desc.mode       = mode;
    push_desc.blank      = (cfg.lcd_control == 32'd0) || !in_buffer;
    push_desc.eof        = last_byte;
    push_desc.x0         = lpu_pkg::DIM_W'(bir_e) << ppb_log;
    push_desc.line_px    = line_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row      <= '0;
      row_number       <= '0;
      frame_byte_count <= '0;
    end else if (push) begin
      byte_in_row      <= byte_in_row_next;
      row_number       <= row_number_next;
      frame_byte_count <= frame_byte_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lpu_queue.sv -----
// two-entry descriptor queue between front and back
// depends on lpu_pkg
`default_nettype none
module lpu_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lpu_pkg::desc_t  push_desc,
  input  wire logic            pop,
  output lpu_pkg::desc_t       head,
  output lpu_pkg::q_stat_t     stat
);

  lpu_pkg::desc_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head       = entry[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lpu_back.sv -----
// back end: walks the pixels of each byte, palette lookup, tint, output register
// depends on lpu_pkg
`default_nettype none
module lpu_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [63:0]         grey_palette,
  input  wire lpu_pkg::desc_t      head,
  input  wire lpu_pkg::q_stat_t    q_stat,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,  // grey_value, red_level, green_level, blue_level
  output logic                     m_tuser,  // last_of_byte
  output logic                     m_tlast   // end_of_frame
);

  logic [2:0]                k;
  logic [2:0]                last_k;
  logic [2:0]                sh;
  logic [7:0]                shifted;
  logic [3:0]                idx, level, n;
  logic [lpu_pkg::DIM_W-1:0] x;
  logic                      visible, emit, last_px;

  assign emit = !q_stat.empty && (!m_tvalid || m_tready);

  always_comb begin
    case (head.mode)
      lpu_pkg::MODE_1BPP: last_k = 3'd7;
      lpu_pkg::MODE_2BPP: last_k = 3'd3;
      default:            last_k = 3'd1;
    endcase
    last_px = (k == last_k);
    sh      = k << head.mode;
    shifted = head.frame_byte >> sh;
    case (head.mode)
      lpu_pkg::MODE_1BPP: idx = {3'b000, shifted[0]};
      lpu_pkg::MODE_2BPP: idx = {2'b00, shifted[1:0]};
      default:            idx = shifted[3:0];
    endcase
    level   = (grey_palette == 64'd0) ? idx : grey_palette[{idx, 2'b00} +: 4];
    x       = head.x0 + lpu_pkg::DIM_W'(k);
    visible = !head.blank && (x < head.line_px);
    n       = visible ? (4'hF - level) : 4'hF;
    pop     = emit && last_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        k <= last_px ? 3'd0 : k + 3'd1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {lpu_pkg::blue_of(n), lpu_pkg::green_of(n), lpu_pkg::red_of(n), {n, n}};
      m_tuser <= last_px;
      m_tlast <= last_px && head.eof;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lcd_pixel_unpack_palette.sv -----
// top level of the lcd pixel unpacker: config registers, front, queue, back
// depends on lpu_pkg, lpu_front, lpu_queue, lpu_back and the defines header
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: frame_byte
//   m_*      out  m_tvalid/m_tready    m_tdata: grey, red, green, blue; tuser; tlast
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// back end: a pixel per cycle unless stalled; 8, 4 or 2 pixels a byte at 1, 2, 4 bpp
// the front takes a byte per cycle while the two-entry queue has room
// a byte's first pixel is registered in the queue entry and then in the output register
// synchronous reset clears position counters, queue and output valid, and resets the config registers
// the back end stalls on m_tready and on an empty queue; cfg writes are always taken
`default_nettype none
`include "lcd_pixel_unpack_palette_defines.svh"
module lcd_pixel_unpack_palette (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // frame_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // grey_value, red_level, green_level, blue_level
  output logic             m_tuser,   // last_of_byte
  output logic             m_tlast,   // end_of_frame
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  lpu_pkg::cfg_t    cfg;
  logic [63:0]      grey_palette;
  logic             push, pop;
  lpu_pkg::desc_t   push_desc, head;
  lpu_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lcd_control    <= 32'd0;
      cfg.display_width  <= lpu_pkg::DIM_W'(640);
      cfg.display_height <= lpu_pkg::DIM_W'(240);
      grey_palette       <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpu_pkg::REG_LCD_CONTROL:    cfg.lcd_control    <= cfg_data[31:0];
        lpu_pkg::REG_GREY_PALETTE:   grey_palette       <= cfg_data;
        lpu_pkg::REG_DISPLAY_WIDTH:  cfg.display_width  <= cfg_data[lpu_pkg::DIM_W-1:0];
        lpu_pkg::REG_DISPLAY_HEIGHT: cfg.display_height <= cfg_data[lpu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  lpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_stat.full),
    .push      (push),
    .push_desc (push_desc)
  );

  lpu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  lpu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .grey_palette (grey_palette),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  `LPU_ASSERT_NOW(a_eof_on_last_px, m_tvalid && m_tlast, m_tuser, "end of frame off byte end")
  `LPU_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  `LPU_ASSERT_NEXT(a_drain, (!m_tvalid || m_tready) && q_stat.empty, !m_tvalid, "pixel from nowhere")
  `LPU_ASSERT_NOW(a_pop_needs_item, pop, !q_stat.empty, "pop of empty queue")

endmodule
`default_nettype wire
